// ===== rtl/ghpf_pkg.sv =====
package ghpf_pkg;

  typedef enum logic [11:0] {
    S_CLR     = 12'b000000000001,
    S_IDLE    = 12'b000000000010,
    S_MAP     = 12'b000000000100,
    S_ACC_RD  = 12'b000000001000,
    S_ACC_WR  = 12'b000000010000,
    S_CTR_RD  = 12'b000000100000,
    S_CTR_CHK = 12'b000001000000,
    S_WIN_RD  = 12'b000010000000,
    S_WIN_ACC = 12'b000100000000,
    S_DIV     = 12'b001000000000,
    S_FIN     = 12'b010000000000,
    S_DONE    = 12'b100000000000
  } state_t;

  typedef enum logic [1:0] {
    KIND_CLEAR    = 2'd0,
    KIND_ACCUM    = 2'd1,
    KIND_CLASSIFY = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_KEPT  = 2'd0,
    VERDICT_OOR   = 2'd1,
    VERDICT_EMPTY = 2'd2,
    VERDICT_LOW   = 2'd3
  } verdict_t;

  localparam int          X_OFFSET_MM    = 1500;
  localparam int          MM_PER_CM      = 10;
  localparam int          THRESH_BITS    = 20;
  localparam int          AVG_BITS       = 20;
  localparam logic [19:0] AVG_MAX        = 20'hFFFFF;
  localparam logic [19:0] THRESH_RESET   = 20'd500;
  localparam int          PADDR_BITS     = 3;
  localparam logic        REG_THRESHOLD  = 1'b0;

endpackage

// ===== rtl/ghpf_if.sv =====
interface ghpf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [14:0] x_mm;
  logic signed [14:0] z_mm;

  modport source (output valid, output kind, output x_mm, output z_mm, input ready);
  modport sink   (input valid, input kind, input x_mm, input z_mm, output ready);
endinterface

interface ghpf_out_if;
  logic        valid;
  logic        ready;
  logic        keep;
  logic [1:0]  verdict;
  logic [19:0] neighbour_average;

  modport source (output valid, output keep, output verdict, output neighbour_average,
                  input ready);
  modport sink   (input valid, input keep, input verdict, input neighbour_average,
                  output ready);
endinterface

// ===== rtl/ghpf_ram.sv =====
module ghpf_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 5000
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/grid_histogram_point_filter.sv =====
// Accumulate: S_MAP, S_ACC_RD, S_ACC_WR, then back to idle. Classify: S_MAP, S_CTR_RD, S_CTR_CHK,
// then the nine-cell window read one cell at a time on the single memory port (S_WIN_RD, then
// S_WIN_ACC), a bit-serial divide of COUNT_BITS + 4 steps, and S_FIN to load the result register.
// Out-of-range points and empty cells skip the window and divide. One item in flight at a time.
// Clear: one entry per cycle over all CELLS_X * CELLS_Z entries, no item taken meanwhile.
// Reset: synchronous active low; threshold to 500, then a clearing pass over the whole grid.
module grid_histogram_point_filter #(
  parameter int CELLS_X    = 100,
  parameter int CELLS_Z    = 50,
  parameter int CELL_CM    = 3,
  parameter int COUNT_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ghpf_in_if.sink                         in_if,
  ghpf_out_if.source                      out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ghpf_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import ghpf_pkg::*;

  localparam int DEPTH   = CELLS_X * CELLS_Z;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = COUNT_BITS + 4;
  localparam int EW      = SW + AVG_BITS;
  localparam int DCW     = $clog2(SW);
  localparam int MW      = 15;
  localparam int QW      = 12;
  localparam int CW      = QW + 1;
  localparam int DIVISOR = MM_PER_CM * CELL_CM;
  localparam int RS      = 24;
  localparam int RW      = 25;
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RS) + DIVISOR - 1) / DIVISOR);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  state_t state_r, state_nxt;
  logic [THRESH_BITS-1:0] thresh_r;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic kind_acc_r, kind_acc_nxt;
  logic [MW-1:0] mag_x_r, mag_x_nxt, mag_z_r, mag_z_nxt;
  logic neg_x_r, neg_x_nxt, neg_z_r, neg_z_nxt;
  logic signed [CW-1:0] cx_r, cx_nxt, cz_r, cz_nxt;
  logic [1:0] dx_r, dx_nxt, dz_r, dz_nxt;
  logic win_vld_r, win_vld_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [3:0] n_r, n_nxt;
  logic [3:0] rem_r, rem_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [1:0] res_verdict_r, res_verdict_nxt;
  logic [AVG_BITS-1:0] res_avg_r, res_avg_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_verdict_r, out_verdict_nxt;
  logic [AVG_BITS-1:0] out_avg_r, out_avg_nxt;

  logic signed [15:0] ax, zw;
  logic [15:0] ax_abs, zw_abs;
  logic [MW+RW-1:0] prod_x, prod_z;
  logic [QW-1:0] qx, qz;
  logic signed [CW:0] nx, nz;
  logic grid_ok;
  logic [AW-1:0] win_addr;
  logic mem_en, mem_we;
  logic [AW-1:0] mem_addr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;
  logic [4:0] rem_sh;
  logic [EW-1:0] avg_w;
  logic cfg_wr;

  ghpf_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? 32'(thresh_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr && paddr[2] == REG_THRESHOLD) begin
      thresh_r <= pwdata[THRESH_BITS-1:0];
    end
  end

  assign ax     = 16'(in_if.x_mm) + 16'sd1500;
  assign zw     = 16'(in_if.z_mm);
  assign ax_abs = ax[15] ? 16'(-ax) : 16'(ax);
  assign zw_abs = zw[15] ? 16'(-zw) : 16'(zw);
  assign prod_x = (MW+RW)'(mag_x_r) * (MW+RW)'(RECIP);
  assign prod_z = (MW+RW)'(mag_z_r) * (MW+RW)'(RECIP);
  assign qx     = prod_x[RS +: QW];
  assign qz     = prod_z[RS +: QW];

  assign nx = (CW+1)'(cx_r) + $signed({{(CW-1){1'b0}}, dx_r}) - (CW+1)'(1);
  assign nz = (CW+1)'(cz_r) + $signed({{(CW-1){1'b0}}, dz_r}) - (CW+1)'(1);
  assign grid_ok = !nx[CW] && (nx < $signed((CW+1)'(CELLS_X)))
                && !nz[CW] && (nz < $signed((CW+1)'(CELLS_Z)));
  assign win_addr = AW'(AW'(nx) * AW'(CELLS_Z)) + AW'(nz);

  assign rem_sh = {rem_r, sum_r[SW-1]};
  assign avg_w  = EW'(sum_r);

  assign in_if.ready              = (state_r == S_IDLE);
  assign out_if.valid             = out_valid_r;
  assign out_if.verdict           = out_verdict_r;
  assign out_if.keep              = (out_verdict_r == VERDICT_KEPT);
  assign out_if.neighbour_average = out_avg_r;

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    kind_acc_nxt    = kind_acc_r;
    mag_x_nxt       = mag_x_r;
    mag_z_nxt       = mag_z_r;
    neg_x_nxt       = neg_x_r;
    neg_z_nxt       = neg_z_r;
    cx_nxt          = cx_r;
    cz_nxt          = cz_r;
    dx_nxt          = dx_r;
    dz_nxt          = dz_r;
    win_vld_nxt     = win_vld_r;
    addr_nxt        = addr_r;
    sum_nxt         = sum_r;
    n_nxt           = n_r;
    rem_nxt         = rem_r;
    dcnt_nxt        = dcnt_r;
    res_verdict_nxt = res_verdict_r;
    res_avg_nxt     = res_avg_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_verdict_nxt = out_verdict_r;
    out_avg_nxt     = out_avg_r;
    mem_en          = 1'b0;
    mem_we          = 1'b0;
    mem_addr        = win_addr;
    mem_wdata       = '0;

    case (state_r)
      S_CLR: begin
        mem_en       = 1'b1;
        mem_we       = 1'b1;
        mem_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_if.valid) begin
          kind_acc_nxt = (in_if.kind == KIND_ACCUM);
          mag_x_nxt    = ax_abs[MW-1:0];
          mag_z_nxt    = zw_abs[MW-1:0];
          neg_x_nxt    = ax[15];
          neg_z_nxt    = zw[15];
          case (in_if.kind)
            KIND_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = S_CLR;
            end
            KIND_ACCUM, KIND_CLASSIFY: state_nxt = S_MAP;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MAP: begin
        cx_nxt    = neg_x_r ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        cz_nxt    = neg_z_r ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
        dx_nxt    = 2'd1;
        dz_nxt    = 2'd1;
        state_nxt = kind_acc_r ? S_ACC_RD : S_CTR_RD;
      end
      S_ACC_RD: begin
        addr_nxt = win_addr;
        if (grid_ok) begin
          mem_en    = 1'b1;
          state_nxt = S_ACC_WR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ACC_WR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = addr_r;
        mem_wdata = (mem_rdata == CNT_MAX) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
        state_nxt = S_IDLE;
      end
      S_CTR_RD: begin
        if (grid_ok) begin
          mem_en    = 1'b1;
          state_nxt = S_CTR_CHK;
        end else begin
          res_verdict_nxt = VERDICT_OOR;
          res_avg_nxt     = '0;
          state_nxt       = S_DONE;
        end
      end
      S_CTR_CHK: begin
        if (mem_rdata == '0) begin
          res_verdict_nxt = VERDICT_EMPTY;
          res_avg_nxt     = '0;
          state_nxt       = S_DONE;
        end else begin
          dx_nxt    = 2'd0;
          dz_nxt    = 2'd0;
          sum_nxt   = '0;
          n_nxt     = '0;
          state_nxt = S_WIN_RD;
        end
      end
      S_WIN_RD: begin
        mem_en      = grid_ok;
        win_vld_nxt = grid_ok;
        state_nxt   = S_WIN_ACC;
      end
      S_WIN_ACC: begin
        if (win_vld_r && mem_rdata != '0) begin
          sum_nxt = sum_r + SW'(mem_rdata);
          n_nxt   = n_r + 4'd1;
        end
        state_nxt = S_WIN_RD;
        if (dz_r == 2'd2) begin
          dz_nxt = 2'd0;
          if (dx_r == 2'd2) begin
            rem_nxt   = '0;
            dcnt_nxt  = DCW'(SW - 1);
            state_nxt = S_DIV;
          end else begin
            dx_nxt = dx_r + 2'd1;
          end
        end else begin
          dz_nxt = dz_r + 2'd1;
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, n_r}) begin
          rem_nxt = 4'(rem_sh - {1'b0, n_r});
          sum_nxt = {sum_r[SW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[3:0];
          sum_nxt = {sum_r[SW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - DCW'(1);
        if (dcnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        res_verdict_nxt = (avg_w >= EW'(thresh_r)) ? VERDICT_KEPT : VERDICT_LOW;
        res_avg_nxt     = (avg_w > EW'(AVG_MAX)) ? AVG_MAX : avg_w[AVG_BITS-1:0];
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = res_verdict_r;
          out_avg_nxt     = res_avg_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_acc_r    <= kind_acc_nxt;
    mag_x_r       <= mag_x_nxt;
    mag_z_r       <= mag_z_nxt;
    neg_x_r       <= neg_x_nxt;
    neg_z_r       <= neg_z_nxt;
    cx_r          <= cx_nxt;
    cz_r          <= cz_nxt;
    dx_r          <= dx_nxt;
    dz_r          <= dz_nxt;
    win_vld_r     <= win_vld_nxt;
    addr_r        <= addr_nxt;
    sum_r         <= sum_nxt;
    n_r           <= n_nxt;
    rem_r         <= rem_nxt;
    dcnt_r        <= dcnt_nxt;
    res_verdict_r <= res_verdict_nxt;
    res_avg_r     <= res_avg_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_avg_r     <= out_avg_nxt;
  end

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLR || state_r == S_ACC_WR))
    else $error("grid write outside clear or accumulate");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> n_r != 4'd0)
    else $error("divide with empty window");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_if.ready)
    else $error("item taken during clear");

endmodule

// ===== test/tb_grid_histogram_point_filter.sv =====
`timescale 1ns / 1ps

module tb_grid_histogram_point_filter;
  import ghpf_pkg::*;

  localparam int CELLS_X    = 100;
  localparam int CELLS_Z    = 50;
  localparam int CELL_CM    = 3;
  localparam int COUNT_BITS = 20;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
  localparam int SETTLE = CELLS_X * CELLS_Z + 100;

  typedef struct packed {
    logic        keep;
    verdict_t    verdict;
    logic [19:0] avg;
  } filter_res_t;

  typedef struct {
    kind_t              kind;
    logic signed [14:0] x;
    logic signed [14:0] z;
    bit                 typed;
    filter_res_t        res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ghpf_in_if  in_ch ();
  ghpf_out_if out_ch ();

  grid_histogram_point_filter i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  longint unsigned grid_cnt [CELLS_X * CELLS_Z];
  logic [19:0]     thresh_m;
  filter_res_t     verdict_q [$];
  stim_row_t       rows [$];
  int              errors;
  int              n_items;
  int              n_results;
  int              n_clears;
  int              n_thresh;
  bit              idle_on;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #20_000_000;
    $display("timeout at %0t", $time);
    $display("grid_histogram_point_filter: mismatch");
    $finish;
  end

  function automatic bit on_grid(int cx, int cz);
    return cx >= 0 && cx < CELLS_X && cz >= 0 && cz < CELLS_Z;
  endfunction

  function automatic void grid_step(kind_t k, logic signed [14:0] x, logic signed [14:0] z);
    int xi;
    int zi;
    int cx;
    int cz;
    longint unsigned total;
    longint unsigned n;
    longint unsigned a;
    filter_res_t r;
    xi = x;
    zi = z;
    cx = ((xi + X_OFFSET_MM) / MM_PER_CM) / CELL_CM;
    cz = (zi / MM_PER_CM) / CELL_CM;
    case (k)
      KIND_CLEAR: begin
        foreach (grid_cnt[i]) grid_cnt[i] = 0;
      end
      KIND_ACCUM: begin
        if (on_grid(cx, cz) && grid_cnt[cx*CELLS_Z+cz] < COUNT_MAX)
          grid_cnt[cx*CELLS_Z+cz]++;
      end
      KIND_CLASSIFY: begin
        r = '{keep: 1'b0, verdict: VERDICT_OOR, avg: 20'd0};
        if (on_grid(cx, cz)) begin
          if (grid_cnt[cx*CELLS_Z+cz] == 0) begin
            r.verdict = VERDICT_EMPTY;
          end else begin
            total = 0;
            n = 0;
            for (int dx = -1; dx <= 1; dx++) begin
              for (int dz = -1; dz <= 1; dz++) begin
                if (on_grid(cx+dx, cz+dz) && grid_cnt[(cx+dx)*CELLS_Z+cz+dz] != 0) begin
                  total += grid_cnt[(cx+dx)*CELLS_Z+cz+dz];
                  n++;
                end
              end
            end
            a = total / n;
            if (a >= thresh_m) begin
              r.verdict = VERDICT_KEPT;
              r.keep = 1'b1;
            end else begin
              r.verdict = VERDICT_LOW;
            end
            r.avg = (a > AVG_MAX) ? AVG_MAX : a[19:0];
          end
        end
        verdict_q = {verdict_q, r};
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(kind_t k, logic signed [14:0] x, logic signed [14:0] z,
                           bit typed, filter_res_t tres);
    if (idle_on && $urandom_range(0, 99) < 35) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.x_mm  <= x;
    in_ch.z_mm  <= z;
    do @(posedge clk); while (!in_ch.ready);
    grid_step(k, x, z);
    if (typed && k == KIND_CLASSIFY) verdict_q[verdict_q.size()-1] = tres;
    if (k == KIND_CLEAR) n_clears++;
    n_items++;
  endtask

  task automatic write_thresh(logic [19:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_BITS'(4 * REG_THRESHOLD);
    pwdata  <= {12'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    thresh_m = v;
    n_thresh++;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[19:0] !== v) begin
      $display("%0t threshold readback: expected %0d actual %0d", $time, v, prdata[19:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void add_row(kind_t k, int x, int z, bit typed, verdict_t v);
    stim_row_t r;
    r.kind = k;
    r.x = x[14:0];
    r.z = z[14:0];
    r.typed = typed;
    r.res = '{keep: 1'b0, verdict: v, avg: 20'd0};
    rows = {rows, r};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= idle_on ? ($urandom_range(0, 99) >= 35) : 1'b1;
    end
  end

  always @(posedge clk) begin
    filter_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (verdict_q.size() == 0) begin
        $display("%0t unexpected item: keep %0b verdict %0d avg %0d", $time,
                 out_ch.keep, out_ch.verdict, out_ch.neighbour_average);
        errors++;
      end else begin
        e = verdict_q.pop_front();
        if (out_ch.keep !== e.keep || out_ch.verdict !== e.verdict ||
            out_ch.neighbour_average !== e.avg) begin
          $display("%0t expected keep %0b verdict %0d avg %0d, actual keep %0b verdict %0d avg %0d",
                   $time, e.keep, e.verdict, e.avg,
                   out_ch.keep, out_ch.verdict, out_ch.neighbour_average);
          errors++;
        end
      end
    end
  end

  initial begin
    int cx;
    int cz;
    int base_x;
    int base_z;
    int sel;
    logic [19:0] phase_thr [6];
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_clears = 0;
    n_thresh = 0;
    idle_on = 1'b1;
    foreach (grid_cnt[i]) grid_cnt[i] = 0;
    thresh_m = THRESH_RESET;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_NONE;
    in_ch.x_mm = '0;
    in_ch.z_mm = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(posedge clk);

    add_row(KIND_CLASSIFY, 0, 0, 1, VERDICT_EMPTY);
    add_row(KIND_CLASSIFY, -16384, 0, 1, VERDICT_OOR);
    add_row(KIND_CLASSIFY, 16383, 16383, 1, VERDICT_OOR);
    add_row(KIND_CLASSIFY, 0, -16384, 1, VERDICT_OOR);
    add_row(KIND_CLASSIFY, -1529, -29, 1, VERDICT_EMPTY);
    add_row(KIND_CLASSIFY, -1530, 0, 1, VERDICT_OOR);
    add_row(KIND_NONE, 0, 0, 0, VERDICT_KEPT);
    add_row(KIND_ACCUM, -1529, -29, 0, VERDICT_KEPT);
    add_row(KIND_CLASSIFY, -1529, -29, 0, VERDICT_KEPT);
    add_row(KIND_ACCUM, 1499, 1499, 0, VERDICT_KEPT);
    add_row(KIND_ACCUM, 1499, 1499, 0, VERDICT_KEPT);
    add_row(KIND_CLASSIFY, 1499, 1499, 0, VERDICT_KEPT);
    add_row(KIND_ACCUM, 1500, 0, 0, VERDICT_KEPT);
    add_row(KIND_CLASSIFY, 1500, 0, 1, VERDICT_OOR);
    add_row(KIND_ACCUM, 0, 1500, 0, VERDICT_KEPT);
    add_row(KIND_ACCUM, 0, 300, 0, VERDICT_KEPT);
    add_row(KIND_ACCUM, 30, 300, 0, VERDICT_KEPT);
    add_row(KIND_ACCUM, 30, 300, 0, VERDICT_KEPT);
    add_row(KIND_CLASSIFY, 0, 300, 0, VERDICT_KEPT);
    add_row(KIND_CLASSIFY, 30, 330, 0, VERDICT_KEPT);
    add_row(KIND_CLEAR, 0, 0, 0, VERDICT_KEPT);
    add_row(KIND_CLASSIFY, 0, 300, 1, VERDICT_EMPTY);
    add_row(KIND_ACCUM, -1, -1, 0, VERDICT_KEPT);
    add_row(KIND_CLASSIFY, -1, -1, 0, VERDICT_KEPT);

    write_thresh(20'd1);
    foreach (rows[i]) send_item(rows[i].kind, rows[i].x, rows[i].z, rows[i].typed, rows[i].res);
    in_ch.valid <= 1'b0;
    drain();

    phase_thr[0] = 20'd3;
    phase_thr[1] = 20'hFFFFF;
    phase_thr[2] = 20'd0;
    phase_thr[3] = 20'd1;
    phase_thr[4] = 20'd6;
    phase_thr[5] = 20'($urandom_range(1, 12));
    for (int p = 0; p < 6; p++) begin
      write_thresh(phase_thr[p]);
      idle_on = (p != 3);
      base_x = $urandom_range(0, CELLS_X - 6);
      base_z = $urandom_range(0, CELLS_Z - 6);
      if (p == 1) begin
        base_x = 0;
        base_z = 0;
      end
      if (p == 4) begin
        base_x = CELLS_X - 6;
        base_z = CELLS_Z - 6;
      end
      for (int j = 0; j < 237; j++) begin
        sel = $urandom_range(0, 999);
        if (sel < 5) begin
          send_item(KIND_CLEAR, 15'($urandom), 15'($urandom), 0, '0);
        end else if (sel < 25) begin
          send_item(KIND_NONE, 15'($urandom), 15'($urandom), 0, '0);
        end else begin
          cx = base_x + $urandom_range(0, 5);
          cz = base_z + $urandom_range(0, 5);
          if ($urandom_range(0, 99) < 85) begin
            send_item((sel < 625) ? KIND_ACCUM : KIND_CLASSIFY,
                      15'(cx * 30 - X_OFFSET_MM + $urandom_range(0, 29)),
                      15'(cz * 30 + $urandom_range(0, 29)), 0, '0);
          end else begin
            send_item((sel < 625) ? KIND_ACCUM : KIND_CLASSIFY,
                      15'($urandom), 15'($urandom), 0, '0);
          end
        end
      end
      in_ch.valid <= 1'b0;
      drain();
    end
    idle_on = 1'b1;

    $display("covered %0d items (%0d clears), %0d results checked, %0d threshold settings",
             n_items, n_clears, n_results, n_thresh);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("grid_histogram_point_filter: match");
    end else begin
      $display("%0d mismatches, %0d items outstanding", errors, verdict_q.size());
      $display("grid_histogram_point_filter: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ghpf_pkg.sv
rtl/ghpf_if.sv
rtl/ghpf_ram.sv
rtl/grid_histogram_point_filter.sv
test/tb_grid_histogram_point_filter.sv
